// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file. Each macro expects a
// clock named clk and an active-low reset named rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, types and pipeline control for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int VECTOR_WIDTH   = 24;
    localparam int NUM_LANES      = 3;

    // Quaternion part products, matrix entries (exact, doubled off-diagonal terms)
    localparam int PROD_W      = 2 * QUAT_WIDTH;
    localparam int ENTRY_W     = PROD_W + 2;
    localparam int LANE_PROD_W = ENTRY_W + VECTOR_WIDTH;
    localparam int SUM_W       = LANE_PROD_W + 2;
    localparam int SHIFT       = 2 * QUAT_FRAC_BITS;
    localparam int TRUNC_W     = SUM_W - SHIFT;

    typedef logic signed [QUAT_WIDTH-1:0]   quat_t;
    typedef logic signed [VECTOR_WIDTH-1:0] vec_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ENTRY_W-1:0]      entry_t;
    typedef logic signed [LANE_PROD_W-1:0]  lane_prod_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    localparam vec_t VEC_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
    localparam vec_t VEC_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

    // Load strobes for the stages below the input register
    typedef struct packed {
        logic prod_en;
        logic entry_en;
        logic mul_en;
        logic sum_en;
    } pipe_en_t;

endpackage

// ----- design/qvr_matrix.sv -----
// ----------------------------------------------------------------------------
// qvr_matrix
// Form the ten quaternion part products, then the nine rotation matrix
// entries, transposed when the word asks for the conjugate rotation.
// ----------------------------------------------------------------------------
module qvr_matrix
    import qvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pipe_en_t en,
    input  quat_t    qw,
    input  quat_t    qx,
    input  quat_t    qy,
    input  quat_t    qz,
    input  logic     inv,
    output entry_t   entry [NUM_LANES][NUM_LANES]
);

    prod_t  ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    prod_t  wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic   inv_reg;
    entry_t m      [NUM_LANES][NUM_LANES];
    entry_t m_next [NUM_LANES][NUM_LANES];
    entry_t entry_reg [NUM_LANES][NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
        end
        else if (en.prod_en)
        begin
            inv_reg <= inv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prod_en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            wz_reg <= qw * qz;
            xz_reg <= qx * qz;
            wy_reg <= qw * qy;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
        end
    end

    always_comb
    begin
        m[0][0] = ENTRY_W'(ww_reg) + ENTRY_W'(xx_reg) - ENTRY_W'(yy_reg) - ENTRY_W'(zz_reg);
        m[1][1] = ENTRY_W'(ww_reg) - ENTRY_W'(xx_reg) + ENTRY_W'(yy_reg) - ENTRY_W'(zz_reg);
        m[2][2] = ENTRY_W'(ww_reg) - ENTRY_W'(xx_reg) - ENTRY_W'(yy_reg) + ENTRY_W'(zz_reg);
        m[0][1] = (ENTRY_W'(xy_reg) - ENTRY_W'(wz_reg)) <<< 1;
        m[1][0] = (ENTRY_W'(xy_reg) + ENTRY_W'(wz_reg)) <<< 1;
        m[0][2] = (ENTRY_W'(xz_reg) + ENTRY_W'(wy_reg)) <<< 1;
        m[2][0] = (ENTRY_W'(xz_reg) - ENTRY_W'(wy_reg)) <<< 1;
        m[1][2] = (ENTRY_W'(yz_reg) - ENTRY_W'(wx_reg)) <<< 1;
        m[2][1] = (ENTRY_W'(yz_reg) + ENTRY_W'(wx_reg)) <<< 1;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                m_next[i][j] = inv_reg ? m[j][i] : m[i][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.entry_en)
        begin
            entry_reg <= m_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ----- design/qvr_lane.sv -----
// ----------------------------------------------------------------------------
// qvr_lane
// One output component: multiply a matrix row by the vector, sum, drop the
// fraction bits and saturate to the vector width.
// ----------------------------------------------------------------------------
module qvr_lane
    import qvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pipe_en_t en,
    input  entry_t   ent [NUM_LANES],
    input  vec_t     vec [NUM_LANES],
    output vec_t     rot,
    output logic     clip
);

    lane_prod_t           prod_reg [NUM_LANES];
    sum_t                 sum;
    logic [TRUNC_W-1:0]   trunc;
    logic [TRUNC_W-VECTOR_WIDTH:0] upper;
    logic                 fits;
    vec_t                 rot_next;
    vec_t                 rot_reg;
    logic                 clip_next;
    logic                 clip_reg;

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                prod_reg[j] <= ent[j] * vec[j];
            end
        end
    end

    always_comb
    begin
        sum       = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
        trunc     = sum[SUM_W-1:SHIFT];
        upper     = trunc[TRUNC_W-1:VECTOR_WIDTH-1];
        fits      = (&upper) || (~|upper);
        clip_next = !fits;
        if (fits)
        begin
            rot_next = trunc[VECTOR_WIDTH-1:0];
        end
        else
        begin
            rot_next = trunc[TRUNC_W-1] ? VEC_MIN : VEC_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (en.sum_en)
        begin
            clip_reg <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot  = rot_reg;
    assign clip = clip_reg;

endmodule

// ----- design/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotate a signed 3-vector by the matrix built from a Q1.14 quaternion.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while in_ready is high and
// returns one rotated vector per word. It is built as a five-stage pipeline:
// input register, quaternion part products, matrix entries, row-by-vector
// products in three parallel lanes, and the lane sums with truncation and
// saturation. Every stage holds its own valid bit and moves on whenever the
// stage after it is empty or moving, so a word can enter while a finished
// result still waits at the output and bubbles collapse on a stall. The
// quaternion is used as is (not normalized); set inverse to rotate by the
// conjugate. Truncation rounds toward minus infinity, and saturated flags
// any component clipped to the 24-bit range.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  quat_t quat_w,
    input  quat_t quat_x,
    input  quat_t quat_y,
    input  quat_t quat_z,
    input  vec_t  vec_x,
    input  vec_t  vec_y,
    input  vec_t  vec_z,
    input  logic  inverse,
    output logic  out_valid,
    input  logic  out_ready,
    output vec_t  rot_x,
    output vec_t  rot_y,
    output vec_t  rot_z,
    output logic  saturated
);

    // Stage valid bits: 1 input, 2 products, 3 entries, 4 lane products, 5 output
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic ready1, ready2, ready3, ready4, ready5;
    logic load1;
    pipe_en_t en;

    quat_t  qw_reg, qx_reg, qy_reg, qz_reg;
    logic   inv_reg;
    vec_t   vec1_reg [NUM_LANES];
    vec_t   vec2_reg [NUM_LANES];
    vec_t   vec3_reg [NUM_LANES];

    entry_t mat_entry [NUM_LANES][NUM_LANES];
    vec_t   lane_rot  [NUM_LANES];
    logic [NUM_LANES-1:0] lane_clip;

    // Ready chain: a stage can load when empty or when it drains this cycle
    always_comb
    begin
        ready5 = !v5_reg || out_ready;
        ready4 = !v4_reg || ready5;
        ready3 = !v3_reg || ready4;
        ready2 = !v2_reg || ready3;
        ready1 = !v1_reg || ready2;

        load1       = in_valid && ready1;
        en.prod_en  = v1_reg && ready2;
        en.entry_en = v2_reg && ready3;
        en.mul_en   = v3_reg && ready4;
        en.sum_en   = v4_reg && ready5;

        v1_next = ready1 ? in_valid : v1_reg;
        v2_next = ready2 ? v1_reg   : v2_reg;
        v3_next = ready3 ? v2_reg   : v3_reg;
        v4_next = ready4 ? v3_reg   : v4_reg;
        v5_next = ready5 ? v4_reg   : v5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            qw_reg      <= quat_w;
            qx_reg      <= quat_x;
            qy_reg      <= quat_y;
            qz_reg      <= quat_z;
            inv_reg     <= inverse;
            vec1_reg[0] <= vec_x;
            vec1_reg[1] <= vec_y;
            vec1_reg[2] <= vec_z;
        end
    end

    // Carry the vector alongside the matrix build
    always_ff @(posedge clk)
    begin
        if (en.prod_en)
        begin
            vec2_reg <= vec1_reg;
        end
        if (en.entry_en)
        begin
            vec3_reg <= vec2_reg;
        end
    end

    qvr_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .qw    (qw_reg),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .qz    (qz_reg),
        .inv   (inv_reg),
        .entry (mat_entry)
    );

    // One lane per output component, each fed one matrix row
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        qvr_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ent   (mat_entry[g]),
            .vec   (vec3_reg),
            .rot   (lane_rot[g]),
            .clip  (lane_clip[g])
        );
    end

    // Merge the lanes: components side by side, clip flags folded into one
    assign in_ready  = ready1;
    assign out_valid = v5_reg;
    assign rot_x     = lane_rot[0];
    assign rot_y     = lane_rot[1];
    assign rot_z     = lane_rot[2];
    assign saturated = |lane_clip;

endmodule

// ----- design/qvr_checker.sv -----
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks on the rotator: output handshake, pipeline latency,
// ready input with an empty output, and consistency of the saturation flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvr_checker
    import qvr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input quat_t quat_w,
    input quat_t quat_x,
    input quat_t quat_y,
    input quat_t quat_z,
    input vec_t  vec_x,
    input vec_t  vec_y,
    input vec_t  vec_z,
    input logic  inverse,
    input logic  out_valid,
    input logic  out_ready,
    input vec_t  rot_x,
    input vec_t  rot_y,
    input vec_t  rot_z,
    input logic  saturated
);

    `ASSERT_IMPL(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(rot_x) && $stable(rot_y) && $stable(rot_z) && $stable(saturated)), "stalled output word changed")

    `ASSERT_IMPL(a_latency, $rose(out_valid), $past(in_valid && in_ready, 5), "output word without input five cycles earlier")

    `ASSERT_IMPL(a_sat_value, out_valid && saturated, rot_x == VEC_MAX || rot_x == VEC_MIN || rot_y == VEC_MAX || rot_y == VEC_MIN || rot_z == VEC_MAX || rot_z == VEC_MIN, "saturation flag without clipped component")

    `ASSERT_PROP(a_ready_empty, out_valid || in_ready, "input stalled with empty output")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
